// ===== sv/pftbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pftbp_pkg
// Shared types and constants of the per-flow token-bucket policer.
// ----------------------------------------------------------------------------
package pftbp_pkg;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int KEY_W  = 96;
    localparam int TOK_W  = 8;
    localparam int TIME_W = 64;
    localparam int ROW_W  = KEY_W + TOK_W + TIME_W;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SHIFT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_MAX   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_PER   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MASK     = 8'd3;

    localparam logic [5:0]  RATE_SHIFT_RST = 6'd10;
    localparam logic [7:0]  BUCKET_MAX_RST = 8'd16;
    localparam logic [7:0]  TOKENS_PER_RST = 8'd1;
    localparam logic [31:0] SRC_MASK_RST   = 32'hFFFF_FF0F;

    localparam logic [1:0] STAT_EXISTING = 2'd0;
    localparam logic [1:0] STAT_NEW      = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_REJECT   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ELAPSE,
        ST_GAIN,
        ST_LEVEL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RES_REJECT,
        RES_FULL,
        RES_NEW,
        RES_HIT
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     search;
        logic     elapse;
        logic     gain;
        logic     level;
        logic     emit;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic reject;
        logic search_done;
        logic hit;
        logic full;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== sv/pftbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pftbp_ctrl
// Sequencer: accept, table search, bucket update steps and result emit.
// ----------------------------------------------------------------------------
module pftbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pftbp_pkg::dp_sts_t sts,
    output pftbp_pkg::dp_cmd_t cmd
);
    import pftbp_pkg::*;

    state_t   state_reg, state_next;
    res_sel_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_REJECT;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (sts.reject)
                begin
                    res_next   = RES_REJECT;
                    state_next = ST_EMIT;
                end
                else if (sts.search_done)
                begin
                    if (sts.hit)
                    begin
                        res_next   = RES_HIT;
                        state_next = ST_ELAPSE;
                    end
                    else
                    begin
                        res_next   = sts.full ? RES_FULL : RES_NEW;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ELAPSE: state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_LEVEL;
            ST_LEVEL:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = res_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SEARCH: cmd.search = !sts.reject;
            ST_ELAPSE: cmd.elapse = 1'b1;
            ST_GAIN:   cmd.gain   = 1'b1;
            ST_LEVEL:  cmd.level  = 1'b1;
            ST_EMIT:   cmd.emit   = !sts.out_busy;
            default:   cmd        = '0;
        endcase
    end

endmodule

// ===== sv/pftbp_datapath.sv =====
// ----------------------------------------------------------------------------
// pftbp_datapath
// Flow table memory, fill count, config registers, bucket arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module pftbp_datapath #(
    parameter int FLOWS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pftbp_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,
    input  pftbp_pkg::dp_cmd_t                cmd,
    output pftbp_pkg::dp_sts_t                sts,
    input  logic                              cfg_valid,
    input  logic [pftbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pftbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pftbp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                        m_tuser
);
    import pftbp_pkg::*;

    localparam int CW = $clog2(FLOWS + 1);
    localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    logic [5:0]  rate_shift_reg;
    logic [7:0]  bucket_max_reg;
    logic [7:0]  tokens_per_reg;
    logic [31:0] src_mask_reg;

    logic [ROW_W-1:0] mem [FLOWS];
    logic [ROW_W-1:0] rd_data_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] ts_reg;
    logic              reject_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     idx_reg;
    logic              pend_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              hit_reg;
    logic [AW-1:0]     hit_addr_reg;
    logic [TOK_W-1:0]  hit_tok_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              gain_ge_reg;
    logic [7:0]        gain_reg;
    logic [7:0]        lvl_reg;
    logic              verd_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_verd_reg;
    logic [1:0]        out_stat_reg;
    logic [7:0]        out_tok_reg;

    logic              step;
    logic              rd_match;
    logic [TIME_W-1:0] gain_full;
    logic [8:0]        sum;
    logic [7:0]        capped;
    logic [7:0]        start_tok;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TOK_W-1:0]  wr_tok;

    assign step     = cmd.search && !hit_reg && (idx_reg < fill_reg);
    assign rd_match = pend_reg && !hit_reg && (rd_data_reg[KEY_W-1:0] == key_reg);

    assign gain_full = elapsed_reg >> rate_shift_reg;
    assign sum       = {1'b0, hit_tok_reg} + {1'b0, gain_reg};
    assign capped    = (gain_ge_reg || (sum > {1'b0, bucket_max_reg})) ? bucket_max_reg
                                                                       : sum[7:0];
    assign start_tok = (bucket_max_reg > tokens_per_reg) ? (bucket_max_reg - tokens_per_reg)
                                                         : 8'd0;

    assign wr_en   = cmd.emit && ((cmd.res_sel == RES_NEW) || (cmd.res_sel == RES_HIT));
    assign wr_addr = (cmd.res_sel == RES_HIT) ? hit_addr_reg : fill_reg[AW-1:0];
    assign wr_tok  = (cmd.res_sel == RES_HIT) ? lvl_reg : start_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_shift_reg <= RATE_SHIFT_RST;
            bucket_max_reg <= BUCKET_MAX_RST;
            tokens_per_reg <= TOKENS_PER_RST;
            src_mask_reg   <= SRC_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATE_SHIFT: rate_shift_reg <= cfg_data[5:0];
                CFG_BUCKET_MAX: bucket_max_reg <= cfg_data[7:0];
                CFG_TOKENS_PER: tokens_per_reg <= cfg_data[7:0];
                CFG_SRC_MASK:   src_mask_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {ts_reg, wr_tok, key_reg};
        if (step)
            rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= step;
            if (cmd.load)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (step)
                    idx_reg <= idx_reg + 1'b1;
                if (rd_match)
                    hit_reg <= 1'b1;
            end
            if (cmd.emit && (cmd.res_sel == RES_NEW))
                fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= {s_tdata[119:104], s_tdata[103:88], s_tdata[87:56],
                           s_tdata[55:24] & src_mask_reg};
            ts_reg     <= s_tdata[183:120];
            reject_reg <= !s_tuser || (s_tdata[15:0] != ETH_IPV4)
                          || (s_tdata[23:16] != PROTO_UDP);
        end
        if (step)
            rd_addr_reg <= idx_reg[AW-1:0];
        if (rd_match)
        begin
            hit_addr_reg <= rd_addr_reg;
            hit_tok_reg  <= rd_data_reg[KEY_W +: TOK_W];
            hit_time_reg <= rd_data_reg[KEY_W+TOK_W +: TIME_W];
        end
        if (cmd.elapse)
            elapsed_reg <= ts_reg - hit_time_reg;
        if (cmd.gain)
        begin
            gain_ge_reg <= gain_full >= {56'd0, bucket_max_reg};
            gain_reg    <= gain_full[7:0];
        end
        if (cmd.level)
        begin
            verd_reg <= capped >= tokens_per_reg;
            lvl_reg  <= (capped >= tokens_per_reg) ? (capped - tokens_per_reg) : capped;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.res_sel)
                RES_REJECT:
                begin
                    out_verd_reg <= 1'b0;
                    out_stat_reg <= STAT_REJECT;
                    out_tok_reg  <= 8'd0;
                end
                RES_FULL:
                begin
                    out_verd_reg <= 1'b1;
                    out_stat_reg <= STAT_FULL;
                    out_tok_reg  <= 8'd0;
                end
                RES_NEW:
                begin
                    out_verd_reg <= 1'b1;
                    out_stat_reg <= STAT_NEW;
                    out_tok_reg  <= start_tok;
                end
                default:
                begin
                    out_verd_reg <= verd_reg;
                    out_stat_reg <= STAT_EXISTING;
                    out_tok_reg  <= lvl_reg;
                end
            endcase
        end
    end

    assign sts.reject      = reject_reg;
    assign sts.search_done = !pend_reg && (hit_reg || (idx_reg == fill_reg));
    assign sts.hit         = hit_reg;
    assign sts.full        = (fill_reg == CW'(FLOWS));
    assign sts.out_busy    = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_tok_reg, out_verd_reg};
    assign m_tuser  = out_stat_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(FLOWS))
        else $error("fill count beyond table depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !m_tready))
        else $error("result emitted over a waiting beat");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");

    a_hit_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (CW'(hit_addr_reg) < fill_reg))
        else $error("hit entry outside filled range");

    a_no_new_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.res_sel == RES_NEW)) |-> !sts.full)
        else $error("insert into full table");

endmodule

// ===== sv/per_flow_token_bucket_policer_core.sv =====
// ----------------------------------------------------------------------------
// per_flow_token_bucket_policer_core
// Per-flow token-bucket policer for UDP over IPv4 packet headers.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata (184b), s_tuser (1b)
//   m_*      out  m_tvalid/m_tready   m_tdata (16b), m_tuser (2b)
//   cfg_*    in   cfg_valid/cfg_ready cfg_index (8b), cfg_data (32b)
//
// The key search reads one table row per cycle from a single port, so the
// time a beat takes grows with the number of flows in the table.
// Rejected packets skip the table search and the bucket update.
// Reset clears the fill count and returns the config to its defaults; no clearing pass of the table.
// A finished result waits in the output register while the next beat is taken.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_policer_core #(
    parameter int FLOWS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // ether_type[15:0], ip_protocol[23:16], src_ip[55:24], dst_ip[87:56],
    // udp_sport[103:88], udp_dport[119:104], timestamp[183:120]
    input  logic [pftbp_pkg::IN_DATA_W-1:0]   s_tdata,
    // header_complete[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // verdict[0], tokens_left[8:1], zero pad[15:9]
    output logic [pftbp_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pftbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pftbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pftbp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    pftbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pftbp_datapath #(
        .FLOWS (FLOWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
